/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks clocked on clk, held off by rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never hold at a clock edge
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent at an edge implies consequent at the same edge
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/bms_pkg.sv */
// ----------------------------------------------------------------------------
// bms_pkg
// types, constants and small tables shared by the gaussian sampler modules
// ----------------------------------------------------------------------------
package bms_pkg;

  localparam int UNIFORM_BITS_DEF     = 32;
  localparam int SAMPLE_FRAC_BITS_DEF = 16;

  // 2 ln 2 in Q28, pi/2 in Q30, one in Q30
  localparam logic [28:0] TWO_LN2_Q28 = 29'd372130559;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;

  // register indexes
  localparam logic [0:0] CFG_MEAN_OFFSET = 1'b0;
  localparam logic [0:0] CFG_STD_SCALE   = 1'b1;

  typedef struct packed {
    logic [31:0] uniform_radius;
    logic [31:0] uniform_angle;
  } req_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               pair_half;
  } rsp_t;

  typedef enum logic {
    OP_DRAW,
    OP_SPARE
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [31:0] u1;
    logic [31:0] turn;
  } op_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_NORM,
    BK_LOG,
    BK_VMUL,
    BK_VADD,
    BK_SQRT,
    BK_SIN_X,
    BK_SIN_X2,
    BK_SIN_MH,
    BK_SIN_MR,
    BK_SIN_DIV,
    BK_SIN_OUT,
    BK_MEM_C,
    BK_MEM_S,
    BK_SCALE
  } bk_state_t;

  // series divisor (2k)(2k+1)
  function automatic logic [7:0] series_div(input logic [2:0] k);
    logic [7:0] d;
    unique case (k)
      3'd1:    d = 8'd6;
      3'd2:    d = 8'd20;
      3'd3:    d = 8'd42;
      3'd4:    d = 8'd72;
      3'd5:    d = 8'd110;
      3'd6:    d = 8'd156;
      3'd7:    d = 8'd210;
      default: d = 8'd1;
    endcase
    return d;
  endfunction

  // floor(2^32 / divisor), quotient estimate at most one low
  function automatic logic [31:0] series_recip(input logic [2:0] k);
    logic [31:0] r;
    unique case (k)
      3'd1:    r = 32'd715827882;
      3'd2:    r = 32'd214748364;
      3'd3:    r = 32'd102261126;
      3'd4:    r = 32'd59652323;
      3'd5:    r = 32'd39045157;
      3'd6:    r = 32'd27531841;
      3'd7:    r = 32'd20452225;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/bms_queue.sv */
// ----------------------------------------------------------------------------
// bms_queue
// two-entry op queue between the front and the back
// ----------------------------------------------------------------------------
module bms_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bms_pkg::op_t    din,
  input  logic            pop,
  output bms_pkg::op_t    dout,
  output bms_pkg::q_stat_t stat
);

  bms_pkg::op_t entry [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;

  assign dout       = entry[rd_ptr];
  assign stat.empty = (count == 2'd0);
  assign stat.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

/* rtl/bms_front.sv */
// ----------------------------------------------------------------------------
// bms_front
// takes request beats, masks the uniforms, tracks the spare, queues ops
// ----------------------------------------------------------------------------
module bms_front #(
  parameter int UNIFORM_BITS = bms_pkg::UNIFORM_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  bms_pkg::req_t    req,
  input  bms_pkg::q_stat_t q_stat,
  output logic             push,
  output bms_pkg::op_t     op
);

  localparam logic [31:0] UMASK = (UNIFORM_BITS >= 32) ? 32'hFFFF_FFFF :
                                  32'((64'd1 << UNIFORM_BITS) - 64'd1);
  localparam int SHR = (UNIFORM_BITS >= 32) ? UNIFORM_BITS - 32 : 0;
  localparam int SHL = (UNIFORM_BITS < 32) ? 32 - UNIFORM_BITS : 0;

  logic        spare_valid;
  logic        accept;
  logic [31:0] u1m;
  logic [31:0] u2m;
  logic        zero;

  assign req_ready = !q_stat.full;
  assign accept    = req_valid && req_ready;
  assign u1m       = req.uniform_radius & UMASK;
  assign u2m       = req.uniform_angle & UMASK;
  assign zero      = (u1m == 32'd0) || (u2m == 32'd0);

  // a held spare wins over the uniforms, a zero draw is dropped
  assign push    = accept && (spare_valid || !zero);
  assign op.kind = spare_valid ? bms_pkg::OP_SPARE : bms_pkg::OP_DRAW;
  assign op.u1   = u1m;
  assign op.turn = (u2m >> SHR) << SHL;

  always_ff @(posedge clk) begin
    if (rst) begin
      spare_valid <= 1'b0;
    end else if (accept) begin
      if (spare_valid) begin
        spare_valid <= 1'b0;
      end else if (!zero) begin
        spare_valid <= 1'b1;
      end
    end
  end

endmodule

/* rtl/bms_back.sv */
// ----------------------------------------------------------------------------
// bms_back
// sequencer around one shared 32x32 multiplier: log, sqrt, sine, scaling
// ----------------------------------------------------------------------------
module bms_back #(
  parameter int UNIFORM_BITS     = bms_pkg::UNIFORM_BITS_DEF,
  parameter int SAMPLE_FRAC_BITS = bms_pkg::SAMPLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  bms_pkg::op_t       head,
  input  bms_pkg::q_stat_t   q_stat,
  output logic               pop,
  input  logic signed [31:0] mean_offset,
  input  logic [23:0]        std_scale,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output bms_pkg::rsp_t      rsp
);

  localparam int SW  = SAMPLE_FRAC_BITS + 4;
  localparam int MSH = 58 - SAMPLE_FRAC_BITS;
  localparam logic [5:0]  UB6     = 6'(UNIFORM_BITS);
  localparam logic [63:0] MEM_LIM = 64'd1 << (SW - 1);
  localparam logic [34:0] TWO_LN2_EXT = 35'(bms_pkg::TWO_LN2_Q28);

  bms_pkg::bk_state_t state, state_next;

  logic [31:0] x;
  logic [4:0]  p;
  logic [28:0] m;
  logic [27:0] f;
  logic [4:0]  cnt;
  logic [56:0] fc;
  logic [63:0] nsh;
  logic [33:0] rem;
  logic [31:0] root;
  logic [31:0] r;
  logic [31:0] turn;
  logic [30:0] targ;
  logic        second;
  logic [30:0] xs;
  logic [31:0] x2;
  logic [30:0] h;
  logic [31:0] y;
  logic [31:0] q0;
  logic [2:0]  k;
  logic [30:0] sa;
  logic [30:0] sb;
  logic signed [SW-1:0] cos_m;
  logic signed [SW-1:0] spare;
  logic signed [SW-1:0] smp;
  logic        half;

  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  logic [29:0] sq;
  logic [4:0]  fidx;
  logic signed [57:0] w;
  logic [34:0] apc;
  logic signed [39:0] vs;
  logic [35:0] cat;
  logic [35:0] trial;
  logic        ge;
  logic [33:0] rem_next;
  logic [31:0] root_next;
  logic [60:0] xr;
  logic [39:0] qd;
  logic [31:0] rem_d;
  logic [31:0] q;
  logic [30:0] cmag;
  logic [30:0] smag;
  logic        cneg;
  logic        sneg;
  logic [SW-1:0] smp_abs;
  logic [63:0] rndp;
  logic [63:0] pmag;
  logic signed [47:0] ps;
  logic signed [47:0] sv;
  logic [31:0] sat;
  logic        load_ok;

  function automatic logic signed [SW-1:0] mk_member(input logic [63:0] pr,
                                                       input logic neg);
    logic [63:0] rnd;
    logic [63:0] mw;
    logic signed [SW-1:0] res;
    rnd = pr + (64'd1 << (MSH - 1));
    mw  = rnd >> MSH;
    if (mw >= MEM_LIM) begin
      res = neg ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    end else begin
      res = neg ? -$signed(mw[SW-1:0]) : $signed(mw[SW-1:0]);
    end
    return res;
  endfunction

  assign prod = mul_a * mul_b;

  // log squaring step
  assign sq   = prod[57:28];
  assign fidx = 5'(5'd28 - cnt);

  // v = ap*C + floor((2^27 - f*C) / 2^28)
  assign w   = $signed({1'b0, 57'd1 << 27}) - $signed({1'b0, fc});
  assign apc = (UB6 - {1'b0, p}) * TWO_LN2_EXT;
  assign vs  = $signed({5'b0, apc}) + 40'(w >>> 28);

  // restoring square root, two radicand bits a step
  assign cat       = {rem, nsh[63:62]};
  assign trial     = {2'b00, root, 2'b01};
  assign ge        = (cat >= trial);
  assign rem_next  = ge ? 34'(cat - trial) : cat[33:0];
  assign root_next = {root[30:0], ge};

  // angle scaling with half-up rounding
  assign xr = prod[60:0] + (61'd1 << 29);

  // series division by reciprocal with one correction
  assign qd    = q0 * bms_pkg::series_div(k);
  assign rem_d = y - qd[31:0];
  assign q     = q0 + {31'd0, (rem_d >= {24'd0, bms_pkg::series_div(k)})};

  // quadrant fold
  always_comb begin
    unique case (turn[31:30])
      2'd0: begin
        cmag = sb; cneg = 1'b0; smag = sa; sneg = 1'b0;
      end
      2'd1: begin
        cmag = sa; cneg = 1'b1; smag = sb; sneg = 1'b0;
      end
      2'd2: begin
        cmag = sb; cneg = 1'b1; smag = sa; sneg = 1'b1;
      end
      default: begin
        cmag = sa; cneg = 1'b0; smag = sb; sneg = 1'b1;
      end
    endcase
  end

  // scale, round half away from zero, add mean, saturate
  assign smp_abs = smp[SW-1] ? SW'(-smp) : SW'(smp);
  assign rndp    = prod + (64'd1 << (SAMPLE_FRAC_BITS - 1));
  assign pmag    = rndp >> SAMPLE_FRAC_BITS;
  assign ps      = $signed({2'b00, pmag[45:0]});
  assign sv      = (smp[SW-1] ? -ps : ps) + 48'(mean_offset);
  always_comb begin
    if (sv > 48'sh0000_7FFF_FFFF) begin
      sat = 32'h7FFF_FFFF;
    end else if (sv < -48'sh0000_8000_0000) begin
      sat = 32'h8000_0000;
    end else begin
      sat = sv[31:0];
    end
  end

  assign load_ok = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bms_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mul_a      = 32'd0;
    mul_b      = 32'd0;
    unique case (state)
      bms_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          pop        = 1'b1;
          state_next = (head.kind == bms_pkg::OP_SPARE) ? bms_pkg::BK_SCALE
                                                         : bms_pkg::BK_NORM;
        end
      end
      bms_pkg::BK_NORM: begin
        if (x[31]) begin
          state_next = bms_pkg::BK_LOG;
        end
      end
      bms_pkg::BK_LOG: begin
        mul_a = {3'b0, m};
        mul_b = {3'b0, m};
        if (cnt == 5'd28) begin
          state_next = bms_pkg::BK_VMUL;
        end
      end
      bms_pkg::BK_VMUL: begin
        mul_a      = {4'b0, f};
        mul_b      = {3'b0, bms_pkg::TWO_LN2_Q28};
        state_next = bms_pkg::BK_VADD;
      end
      bms_pkg::BK_VADD: begin
        state_next = bms_pkg::BK_SQRT;
      end
      bms_pkg::BK_SQRT: begin
        if (cnt == 5'd31) begin
          state_next = bms_pkg::BK_SIN_X;
        end
      end
      bms_pkg::BK_SIN_X: begin
        mul_a      = {1'b0, targ};
        mul_b      = bms_pkg::HALF_PI_Q30;
        state_next = bms_pkg::BK_SIN_X2;
      end
      bms_pkg::BK_SIN_X2: begin
        mul_a      = {1'b0, xs};
        mul_b      = {1'b0, xs};
        state_next = bms_pkg::BK_SIN_MH;
      end
      bms_pkg::BK_SIN_MH: begin
        mul_a      = x2;
        mul_b      = {1'b0, h};
        state_next = bms_pkg::BK_SIN_MR;
      end
      bms_pkg::BK_SIN_MR: begin
        mul_a      = y;
        mul_b      = bms_pkg::series_recip(k);
        state_next = bms_pkg::BK_SIN_DIV;
      end
      bms_pkg::BK_SIN_DIV: begin
        state_next = (k == 3'd1) ? bms_pkg::BK_SIN_OUT : bms_pkg::BK_SIN_MH;
      end
      bms_pkg::BK_SIN_OUT: begin
        mul_a      = {1'b0, xs};
        mul_b      = {1'b0, h};
        state_next = second ? bms_pkg::BK_MEM_C : bms_pkg::BK_SIN_X;
      end
      bms_pkg::BK_MEM_C: begin
        mul_a      = r;
        mul_b      = {1'b0, cmag};
        state_next = bms_pkg::BK_MEM_S;
      end
      bms_pkg::BK_MEM_S: begin
        mul_a      = r;
        mul_b      = {1'b0, smag};
        state_next = bms_pkg::BK_SCALE;
      end
      bms_pkg::BK_SCALE: begin
        mul_a = 32'(smp_abs);
        mul_b = {8'b0, std_scale};
        if (load_ok) begin
          state_next = bms_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = bms_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == bms_pkg::BK_SCALE && load_ok) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      bms_pkg::BK_IDLE: begin
        if (pop) begin
          smp    <= spare;
          half   <= 1'b1;
          x      <= head.u1;
          p      <= 5'd31;
          turn   <= head.turn;
          targ   <= {1'b0, head.turn[29:0]};
          second <= 1'b0;
          f      <= 28'd0;
          cnt    <= 5'd1;
        end
      end
      bms_pkg::BK_NORM: begin
        if (x[31]) begin
          m <= x[31:3];
        end else begin
          x <= x << 1;
          p <= p - 5'd1;
        end
      end
      bms_pkg::BK_LOG: begin
        if (sq[29]) begin
          m       <= sq[29:1];
          f[fidx] <= 1'b1;
        end else begin
          m <= sq[28:0];
        end
        cnt <= cnt + 5'd1;
      end
      bms_pkg::BK_VMUL: begin
        fc <= prod[56:0];
      end
      bms_pkg::BK_VADD: begin
        nsh  <= {vs[35:0], 28'd0};
        rem  <= 34'd0;
        root <= 32'd0;
        cnt  <= 5'd0;
      end
      bms_pkg::BK_SQRT: begin
        rem  <= rem_next;
        root <= root_next;
        nsh  <= nsh << 2;
        cnt  <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          r <= root_next;
        end
      end
      bms_pkg::BK_SIN_X: begin
        xs <= xr[60:30];
      end
      bms_pkg::BK_SIN_X2: begin
        x2 <= prod[61:30];
        h  <= bms_pkg::ONE_Q30;
        k  <= 3'd7;
      end
      bms_pkg::BK_SIN_MH: begin
        y <= prod[61:30];
      end
      bms_pkg::BK_SIN_MR: begin
        q0 <= prod[63:32];
      end
      bms_pkg::BK_SIN_DIV: begin
        h <= bms_pkg::ONE_Q30 - q[30:0];
        k <= k - 3'd1;
      end
      bms_pkg::BK_SIN_OUT: begin
        if (!second) begin
          sa     <= prod[60:30];
          targ   <= bms_pkg::ONE_Q30 - targ;
          second <= 1'b1;
        end else begin
          sb <= prod[60:30];
        end
      end
      bms_pkg::BK_MEM_C: begin
        cos_m <= mk_member(prod, cneg);
      end
      bms_pkg::BK_MEM_S: begin
        spare <= mk_member(prod, sneg);
        smp   <= cos_m;
        half  <= 1'b0;
      end
      bms_pkg::BK_SCALE: begin
        if (load_ok) begin
          rsp.sample    <= sat;
          rsp.pair_half <= half;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/box_muller_gaussian_sampler_unit.sv */
// ----------------------------------------------------------------------------
// box_muller_gaussian_sampler_unit
// box-muller normal sampler: uniform pairs in, scaled Q16.16 samples out
// ----------------------------------------------------------------------------
//  channel   direction  handshake              payload
//  req       in         req_valid / req_ready  uniform_radius, uniform_angle
//  rsp       out        rsp_valid / rsp_ready  sample, pair_half
//  cfg       in         cfg_we                 cfg_index, cfg_wdata
//
//  a drawn pair runs a bit-serial normalise, 28 log squarings, 32 root steps and
//  two sine series; log, sine and scaling share one 32x32 multiplier; a spare
//  beat goes straight to scaling, a rejected zero beat is dropped unqueued
//  up to two ops queue while the sequencer is busy; req_ready drops when full
//  rsp holds in its register until taken; the sequencer waits on it
//  synchronous active-high reset clears the spare flag, queue and sequencer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_muller_gaussian_sampler_unit #(
  parameter int UNIFORM_BITS     = bms_pkg::UNIFORM_BITS_DEF,
  parameter int SAMPLE_FRAC_BITS = bms_pkg::SAMPLE_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bms_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bms_pkg::rsp_t rsp,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);

  // configuration registers
  logic signed [31:0] mean_offset;
  logic [23:0]        std_scale;

  // front to queue, queue to back
  logic             q_push;
  logic             q_pop;
  bms_pkg::op_t     q_din;
  bms_pkg::op_t     q_head;
  bms_pkg::q_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_offset <= 32'sd0;
      std_scale   <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bms_pkg::CFG_MEAN_OFFSET: mean_offset <= cfg_wdata;
        bms_pkg::CFG_STD_SCALE:   std_scale   <= cfg_wdata[23:0];
        default: begin
        end
      endcase
    end
  end

  // classify beats: spare, fresh draw or dropped zero
  bms_front #(
    .UNIFORM_BITS(UNIFORM_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .q_stat   (q_stat),
    .push     (q_push),
    .op       (q_din)
  );

  // decouples beat intake from the long arithmetic
  bms_queue u_queue (
    .clk (clk),
    .rst (rst),
    .push(q_push),
    .din (q_din),
    .pop (q_pop),
    .dout(q_head),
    .stat(q_stat)
  );

  // arithmetic sequencer and output register
  bms_back #(
    .UNIFORM_BITS    (UNIFORM_BITS),
    .SAMPLE_FRAC_BITS(SAMPLE_FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .mean_offset(mean_offset),
    .std_scale  (std_scale),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp)
  );

  // front must never push into a full queue
  `ASSERT_IMPLY(a_no_overflow, q_push, !q_stat.full, "op pushed into full queue")
  // back must never pop an empty queue
  `ASSERT_NEVER(a_no_underflow, q_pop && q_stat.empty, "op popped from empty queue")

endmodule
